/* hdl/tte_pkg.sv */
// shared widths, constants and pipeline types for the taylor trig evaluator
package tte_pkg;

  localparam int XW   = 32;  // operand width, q3.28
  localparam int FRAC = 28;  // fraction bits of the series values
  localparam int TW   = 38;  // sine and cosine term magnitude
  localparam int M1W  = 41;  // term times |x|
  localparam int M2W  = 44;  // term times x squared
  localparam int PW   = 29;  // arcsine term magnitude
  localparam int AW   = 32;  // arcsine sum
  localparam int SW   = 44;  // signed series sums

  localparam logic [XW-1:0] ONE_Q28 = 32'h1000_0000;

  localparam logic [63:0] PI_NUM       = 64'd245850922;
  localparam logic [63:0] PI_DEN       = 64'd78256779;
  localparam logic [63:0] PI_HALF_FULL = ((PI_NUM << 27) + PI_DEN / 2) / PI_DEN;
  localparam logic [XW-1:0] PI_HALF_Q28 = PI_HALF_FULL[XW-1:0];

  typedef enum logic [2:0] {
    OP_SIN  = 3'd0,
    OP_COS  = 3'd1,
    OP_TAN  = 3'd2,
    OP_ASIN = 3'd3,
    OP_ACOS = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DOM = 2'd1,
    ST_SAT = 2'd2
  } status_e;

  // request and partial sums that travel along the chain
  typedef struct packed {
    logic                 valid;
    op_e                  op;
    logic                 neg;
    logic [XW-1:0]        ax;
    logic signed [SW-1:0] s_sum;
    logic signed [SW-1:0] c_sum;
    logic [AW-1:0]        a_sum;
  } side_t;

  // running series terms handed from cell to cell
  typedef struct packed {
    logic [TW-1:0] ts;
    logic [TW-1:0] tc;
    logic [PW-1:0] pa;
  } term_t;

endpackage

/* hdl/taylor_trig_evaluator.sv */
// top level: input stage, chain of series cells, tangent divider and output buffer
//
// sine, cosine, tangent, arcsine and arccosine by truncated taylor series.
// input stream: s_axis_tdata carries a signed q3.28 operand, s_axis_tuser the
// opcode (0 sin, 1 cos, 2 tan, 3 asin, 4 acos). a request is taken on an edge
// with tvalid and tready high. output stream: m_axis_tdata is the signed q7.24
// result, m_axis_tuser the status (0 ok, 1 domain error, 2 saturated).
// one request enters per cycle while s_axis_tready is high; every request yields
// exactly one result, in order. the path from acceptance to m_axis_tvalid is one
// input stage, eight stages per series cell (two rounded multiplies and a
// reciprocal division by a constant), 34 stages of the bit-per-stage tangent
// divider and the output register. an output register plus a one-entry skid
// stage decouple the sides: when the receiver stalls, one more result lands in
// the skid stage and then the whole pipeline holds and s_axis_tready falls.
// reset empties the pipeline and both output stages; the data registers are not reset.
module taylor_trig_evaluator #(
  parameter int TERMS = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [tte_pkg::XW-1:0]  s_axis_tdata,   // operand
  input  logic [2:0]              s_axis_tuser,   // opcode
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [31:0]             m_axis_tdata,   // result
  output logic [1:0]              m_axis_tuser    // status
);
  import tte_pkg::*;

  localparam int DW  = 30;
  localparam int QW  = 33;
  localparam int DNW = DW + 24 + 1;

  typedef enum logic [1:0] {
    KIND_VAL = 2'd0,
    KIND_TAN = 2'd1,
    KIND_DOM = 2'd2
  } kind_e;

  typedef struct packed {
    logic                 valid;
    kind_e                kind;
    logic signed [SW-1:0] v;
    logic                 tneg;
    logic                 sneg;
    logic                 czero;
  } post_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] result;
  } res_t;

  function automatic res_t pack_q24(input logic neg, input logic [SW-1:0] mag);
    res_t r;
    r.status = ST_OK;
    if (!neg) begin
      if (mag > SW'(32'h7FFF_FFFF)) begin
        r.status = ST_SAT;
        r.result = 32'h7FFF_FFFF;
      end else begin
        r.result = mag[31:0];
      end
    end else begin
      if (mag > SW'(32'h8000_0000)) begin
        r.status = ST_SAT;
        r.result = 32'h8000_0000;
      end else begin
        r.result = ~mag[31:0] + 32'd1;
      end
    end
    return r;
  endfunction

  logic                 adv;
  side_t                in_q;
  side_t                side_c [TERMS+1];
  term_t                term_c [TERMS+1];
  side_t                fin;
  logic signed [SW-1:0] s_sig, a_sig;
  logic [SW-1:0]        s_mag, c_mag, v_mag, t_mag;
  post_t                post_d;
  post_t                pd_q [QW+1];
  post_t                fp;
  logic [DNW-1:0]       div_n;
  logic [DW-1:0]        div_d;
  logic [QW-1:0]        div_q;
  logic                 div_ovf;
  res_t                 res_d, out_q, skid_q;
  logic                 out_v_q, skid_v_q, fin_valid;

  assign adv           = !skid_v_q;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (adv) begin
      in_q.valid <= s_axis_tvalid;
      in_q.op    <= op_e'(s_axis_tuser);
      in_q.neg   <= s_axis_tdata[XW-1];
      in_q.ax    <= s_axis_tdata[XW-1] ? ~s_axis_tdata + XW'(1) : s_axis_tdata;
      in_q.s_sum <= '0;
      in_q.c_sum <= '0;
      in_q.a_sum <= '0;
    end
  end

  assign side_c[0] = in_q;

  always_comb begin
    term_c[0].ts = TW'(in_q.ax);
    term_c[0].tc = TW'(ONE_Q28);
    term_c[0].pa = in_q.ax[PW-1:0];
  end

  for (genvar k = 0; k < TERMS; k++) begin : g_cell
    tte_cell #(.K(k)) u_cell (
      .clk_i,
      .rst_ni,
      .en_i  (adv),
      .side_i(side_c[k]),
      .term_i(term_c[k]),
      .side_o(side_c[k+1]),
      .term_o(term_c[k+1])
    );
  end

  assign fin = side_c[TERMS];

  always_comb begin
    s_sig = fin.neg ? -fin.s_sum : fin.s_sum;
    a_sig = fin.neg ? -$signed(SW'(fin.a_sum)) : $signed(SW'(fin.a_sum));
    s_mag = s_sig[SW-1] ? SW'(-s_sig) : SW'(s_sig);
    c_mag = fin.c_sum[SW-1] ? SW'(-fin.c_sum) : SW'(fin.c_sum);

    post_d.valid = fin.valid;
    post_d.kind  = KIND_DOM;
    post_d.v     = '0;
    post_d.tneg  = s_sig[SW-1] ^ fin.c_sum[SW-1];
    post_d.sneg  = s_sig[SW-1];
    post_d.czero = fin.c_sum == '0;

    unique case (fin.op)
      OP_SIN: begin
        post_d.kind = KIND_VAL;
        post_d.v    = s_sig;
      end
      OP_COS: begin
        post_d.kind = KIND_VAL;
        post_d.v    = fin.c_sum;
      end
      OP_TAN: begin
        if (fin.ax <= PI_HALF_Q28) post_d.kind = KIND_TAN;
      end
      OP_ASIN: begin
        if (fin.ax <= ONE_Q28) begin
          post_d.kind = KIND_VAL;
          post_d.v    = a_sig;
        end
      end
      OP_ACOS: begin
        if (fin.ax <= ONE_Q28) begin
          post_d.kind = KIND_VAL;
          post_d.v    = $signed(SW'(PI_HALF_Q28)) - a_sig;
        end
      end
      default: post_d.kind = KIND_DOM;
    endcase

    // rounded sin/cos in q24: (sm << 24 + cm/2) / cm
    div_n = (DNW'(s_mag[DW-1:0]) << 24) + DNW'(c_mag[DW-1:1]);
    div_d = c_mag[DW-1:0];
  end

  tte_div #(.NW(DNW), .DW(DW), .QW(QW)) u_div (
    .clk_i,
    .en_i (adv),
    .n_i  (div_n),
    .d_i  (div_d),
    .q_o  (div_q),
    .ovf_o(div_ovf)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= QW; i++) pd_q[i] <= '0;
    end else if (adv) begin
      pd_q[0] <= post_d;
      for (int i = 1; i <= QW; i++) pd_q[i] <= pd_q[i-1];
    end
  end

  assign fp        = pd_q[QW];
  assign fin_valid = fp.valid && adv;

  always_comb begin
    v_mag = fp.v[SW-1] ? SW'(-fp.v) : SW'(fp.v);
    t_mag = div_ovf ? '1 : SW'(div_q);
    unique case (fp.kind)
      KIND_VAL: res_d = pack_q24(fp.v[SW-1], (v_mag + SW'(8)) >> 4);
      KIND_TAN: begin
        if (fp.czero) begin
          res_d.status = ST_SAT;
          res_d.result = fp.sneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          res_d = pack_q24(fp.tneg, t_mag);
        end
      end
      default: begin
        res_d.status = ST_DOM;
        res_d.result = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && m_axis_tready) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= fin_valid;
      end
    end else if (!out_v_q) begin
      out_v_q <= fin_valid;
    end else if (fin_valid) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && m_axis_tready) begin
      out_q <= skid_v_q ? skid_q : res_d;
    end else if (!out_v_q) begin
      out_q <= res_d;
    end else if (fin_valid) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q.result;
  assign m_axis_tuser  = out_q.status;

endmodule

/* hdl/tte_qmul.sv */
// two-stage rounded q28 product of an unsigned term and an unsigned magnitude
module tte_qmul #(
  parameter int AW = 38,
  parameter int BW = 32,
  parameter int OW = 41
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic [OW-1:0] p_o
);
  import tte_pkg::*;

  localparam int AH  = AW / 2;
  localparam int PPW = AW - AH + BW;
  localparam int FW  = AW + BW + 1;

  logic [PPW-1:0] pp_lo_q, pp_hi_q;
  logic [FW-1:0]  sum;
  logic [OW-1:0]  p_q;

  assign sum = (FW'(pp_hi_q) << AH) + FW'(pp_lo_q) + (FW'(1) << (FRAC - 1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_lo_q <= PPW'(a_i[AH-1:0]) * PPW'(b_i);
      pp_hi_q <= PPW'(a_i[AW-1:AH]) * PPW'(b_i);
      p_q     <= sum[FRAC +: OW];
    end
  end

  assign p_o = p_q;

endmodule

/* hdl/tte_cdiv.sv */
// four-stage rounded division by a constant, optional constant premultiply
module tte_cdiv #(
  parameter int W  = 44,
  parameter int M  = 1,
  parameter int D  = 2,
  parameter int OW = 38
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [W-1:0]  x_i,
  output logic [OW-1:0] q_o
);
  localparam int MB  = $clog2(M + 1);
  localparam int NW  = W + MB + 1;
  localparam int H   = (NW + 2) / 2;
  localparam int HW2 = 2 * H;
  localparam int HW4 = 4 * H;
  localparam logic [HW2-1:0] RECIP = HW2'((65'd1 << NW) / D);
  localparam logic [NW-1:0]  HALF  = NW'(D / 2);

  logic [NW-1:0]  n0_q, n1_q, n2_q, q0_q, q_q;
  logic [HW2-1:0] n_ext;
  logic [HW2-1:0] pp_q [4];
  logic [HW4-1:0] prod;
  logic [NW-1:0]  rem;

  assign n_ext = HW2'(n0_q);
  assign prod  = HW4'(pp_q[0]) + (HW4'(pp_q[1]) << H) + (HW4'(pp_q[2]) << H)
               + (HW4'(pp_q[3]) << HW2);
  // reciprocal estimate is low by at most one
  assign rem   = n2_q - q0_q * NW'(D);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n0_q    <= NW'(x_i) * NW'(M) + HALF;
      pp_q[0] <= HW2'(n_ext[H-1:0]) * HW2'(RECIP[H-1:0]);
      pp_q[1] <= HW2'(n_ext[H-1:0]) * HW2'(RECIP[HW2-1:H]);
      pp_q[2] <= HW2'(n_ext[HW2-1:H]) * HW2'(RECIP[H-1:0]);
      pp_q[3] <= HW2'(n_ext[HW2-1:H]) * HW2'(RECIP[HW2-1:H]);
      n1_q    <= n0_q;
      q0_q    <= prod[NW +: NW];
      n2_q    <= n1_q;
      q_q     <= (rem >= NW'(D)) ? q0_q + NW'(1) : q0_q;
    end
  end

  assign q_o = q_q[OW-1:0];

endmodule

/* hdl/tte_div.sv */
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module tte_div #(
  parameter int NW = 55,
  parameter int DW = 30,
  parameter int QW = 33
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic [QW-1:0] q_o,
  output logic          ovf_o
);
  localparam int CW = DW + QW;

  logic [CW-1:0] rem_q [QW+1];
  logic [DW-1:0] d_q   [QW+1];
  logic [QW-1:0] q_q   [QW+1];
  logic          ovf_q [QW+1];
  logic [CW-1:0] dsh   [QW];
  logic          take  [QW];

  always_comb begin
    for (int i = 0; i < QW; i++) begin
      dsh[i]  = CW'(d_q[i]) << (QW - 1 - i);
      take[i] = rem_q[i] >= dsh[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= CW'(n_i);
      d_q[0]   <= d_i;
      q_q[0]   <= '0;
      // quotient would not fit in qw bits
      ovf_q[0] <= (n_i >> QW) >= NW'(d_i);
      for (int i = 0; i < QW; i++) begin
        rem_q[i+1] <= take[i] ? rem_q[i] - dsh[i] : rem_q[i];
        d_q[i+1]   <= d_q[i];
        q_q[i+1]   <= q_q[i] | (QW'(take[i]) << (QW - 1 - i));
        ovf_q[i+1] <= ovf_q[i];
      end
    end
  end

  assign q_o   = q_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

/* hdl/tte_cell.sv */
// one series term: adds it to the sums and forms the next sine, cosine and arcsine terms
module tte_cell #(
  parameter int K = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  tte_pkg::side_t side_i,
  input  tte_pkg::term_t term_i,
  output tte_pkg::side_t side_o,
  output tte_pkg::term_t term_o
);
  import tte_pkg::*;

  localparam int   DS  = (2 * K + 2) * (2 * K + 3);
  localparam int   DC  = (2 * K + 1) * (2 * K + 2);
  localparam int   MA  = 2 * K + 1;
  localparam int   DA  = 2 * K + 2;
  localparam int   DT  = 2 * K + 1;
  localparam int   LAT = 8;
  localparam int   AT  = 4;
  localparam logic ODD = (K % 2) == 1;

  side_t           side_q [LAT];
  side_t           side_in;
  side_t           side_at;
  logic [M1W-1:0]  s_m1, c_m1;
  logic [M2W-1:0]  s_m2, c_m2;
  logic [TW-1:0]   s_nx, c_nx;
  logic [PW-1:0]   a_m1, a_m2, a_nx, a_term;

  always_comb begin
    side_in = side_i;
    if (ODD) begin
      side_in.s_sum = side_i.s_sum - $signed(SW'(term_i.ts));
      side_in.c_sum = side_i.c_sum - $signed(SW'(term_i.tc));
    end else begin
      side_in.s_sum = side_i.s_sum + $signed(SW'(term_i.ts));
      side_in.c_sum = side_i.c_sum + $signed(SW'(term_i.tc));
    end
  end

  // arcsine term is added at side_q[AT-1], in step with the a_term divider
  always_comb begin
    side_at       = side_q[AT-1];
    side_at.a_sum = side_q[AT-1].a_sum + AW'(a_term);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) side_q[i] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_in;
      for (int i = 1; i < LAT; i++) side_q[i] <= (i == AT) ? side_at : side_q[i-1];
    end
  end

  tte_qmul #(.AW(TW), .BW(XW), .OW(M1W)) u_s_m1 (
    .clk_i, .en_i, .a_i(term_i.ts), .b_i(side_i.ax), .p_o(s_m1));
  tte_qmul #(.AW(M1W), .BW(XW), .OW(M2W)) u_s_m2 (
    .clk_i, .en_i, .a_i(s_m1), .b_i(side_q[1].ax), .p_o(s_m2));
  tte_cdiv #(.W(M2W), .M(1), .D(DS), .OW(TW)) u_s_dv (
    .clk_i, .en_i, .x_i(s_m2), .q_o(s_nx));

  tte_qmul #(.AW(TW), .BW(XW), .OW(M1W)) u_c_m1 (
    .clk_i, .en_i, .a_i(term_i.tc), .b_i(side_i.ax), .p_o(c_m1));
  tte_qmul #(.AW(M1W), .BW(XW), .OW(M2W)) u_c_m2 (
    .clk_i, .en_i, .a_i(c_m1), .b_i(side_q[1].ax), .p_o(c_m2));
  tte_cdiv #(.W(M2W), .M(1), .D(DC), .OW(TW)) u_c_dv (
    .clk_i, .en_i, .x_i(c_m2), .q_o(c_nx));

  tte_qmul #(.AW(PW), .BW(PW), .OW(PW)) u_a_m1 (
    .clk_i, .en_i, .a_i(term_i.pa), .b_i(side_i.ax[PW-1:0]), .p_o(a_m1));
  tte_qmul #(.AW(PW), .BW(PW), .OW(PW)) u_a_m2 (
    .clk_i, .en_i, .a_i(a_m1), .b_i(side_q[1].ax[PW-1:0]), .p_o(a_m2));
  tte_cdiv #(.W(PW), .M(MA), .D(DA), .OW(PW)) u_a_dv (
    .clk_i, .en_i, .x_i(a_m2), .q_o(a_nx));
  tte_cdiv #(.W(PW), .M(1), .D(DT), .OW(PW)) u_a_tm (
    .clk_i, .en_i, .x_i(term_i.pa), .q_o(a_term));

  always_comb begin
    term_o.ts = s_nx;
    term_o.tc = c_nx;
    term_o.pa = a_nx;
  end

  assign side_o = side_q[LAT-1];

endmodule

/* tb/tte_checker.sv */
// checker for the taylor trig evaluator: predicts each result and compares it
`timescale 1ns / 1ps

module tte_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);
  import tte_pkg::*;

  localparam int NTERMS = 6;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } trig_result_t;

  trig_result_t expected_q[$];
  int fails;

  function automatic logic [63:0] q28_mul(logic [63:0] t, logic [63:0] ax);
    logic [63:0] hi, lo;
    hi = t >> 32;
    lo = t & 64'hFFFF_FFFF;
    return ((hi * ax) << 4) + ((lo * ax + 64'h800_0000) >> 28);
  endfunction

  function automatic logic [63:0] rdiv(logic [63:0] n, logic [63:0] d);
    return (n + d / 2) / d;
  endfunction

  function automatic logic signed [63:0] sin_sum(logic [63:0] ax);
    logic [63:0] t;
    logic signed [63:0] s;
    t = ax;
    s = 0;
    for (int k = 0; k < NTERMS; k++) begin
      s = k[0] ? s - $signed(t) : s + $signed(t);
      t = rdiv(q28_mul(q28_mul(t, ax), ax), 64'(2*k+2) * 64'(2*k+3));
    end
    return s;
  endfunction

  function automatic logic signed [63:0] cos_sum(logic [63:0] ax);
    logic [63:0] t;
    logic signed [63:0] s;
    t = 64'(ONE_Q28);
    s = 0;
    for (int k = 0; k < NTERMS; k++) begin
      s = k[0] ? s - $signed(t) : s + $signed(t);
      t = rdiv(q28_mul(q28_mul(t, ax), ax), 64'(2*k+1) * 64'(2*k+2));
    end
    return s;
  endfunction

  function automatic logic signed [63:0] asin_sum(logic [63:0] ax);
    logic [63:0] p;
    logic signed [63:0] s;
    p = ax;
    s = 0;
    for (int k = 0; k < NTERMS; k++) begin
      s = s + $signed(rdiv(p, 64'(2*k+1)));
      p = rdiv(q28_mul(q28_mul(p, ax), ax) * 64'(2*k+1), 64'(2*k+2));
    end
    return s;
  endfunction

  function automatic trig_result_t sat_pack(logic neg, logic [63:0] mag);
    trig_result_t r;
    r.status = ST_OK;
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        r.status = ST_SAT;
        r.value  = 32'h7FFF_FFFF;
      end else begin
        r.value = mag[31:0];
      end
    end else if (mag > 64'h8000_0000) begin
      r.status = ST_SAT;
      r.value  = 32'h8000_0000;
    end else begin
      r.value = 32'(64'd0 - mag);
    end
    return r;
  endfunction

  function automatic trig_result_t to_q24(logic signed [63:0] v);
    logic [63:0] mag;
    mag = v < 0 ? 64'd0 - 64'(v) : 64'(v);
    return sat_pack(v < 0, (mag + 8) >> 4);
  endfunction

  function automatic trig_result_t trig_predict(logic [2:0] op, logic [31:0] x);
    trig_result_t r;
    logic neg, sneg, cneg;
    logic [63:0] ax, sm, cm;
    logic signed [63:0] v, sv, cv, half_pi;
    half_pi = $signed(64'(PI_HALF_Q28));
    neg = x[31];
    ax  = neg ? 64'(32'(-x)) : 64'(x);
    if (neg && ax == 0) ax = 64'h8000_0000;
    r = '{value: 32'd0, status: ST_DOM};
    case (op)
      OP_SIN: begin
        v = sin_sum(ax);
        r = to_q24(neg ? -v : v);
      end
      OP_COS: r = to_q24(cos_sum(ax));
      OP_TAN: begin
        if ($signed(ax) <= half_pi) begin
          sv = sin_sum(ax);
          cv = cos_sum(ax);
          if (neg) sv = -sv;
          sneg = sv < 0;
          cneg = cv < 0;
          sm = sneg ? 64'd0 - 64'(sv) : 64'(sv);
          cm = cneg ? 64'd0 - 64'(cv) : 64'(cv);
          if (cm == 0) begin
            r.status = ST_SAT;
            r.value  = sneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end else begin
            r = sat_pack(sneg != cneg, rdiv(sm << 24, cm));
          end
        end
      end
      OP_ASIN, OP_ACOS: begin
        if (ax <= 64'(ONE_Q28)) begin
          v = asin_sum(ax);
          if (neg) v = -v;
          if (op == OP_ACOS) v = half_pi - v;
          r = to_q24(v);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    trig_result_t exp_r;
    if (!rst_ni) begin
      expected_q.delete();
      fails <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(trig_predict(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $display("%t: unexpected result expected none actual %h/%0d", $time,
                   m_axis_tdata, m_axis_tuser);
          fails <= fails + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.value !== m_axis_tdata || exp_r.status !== m_axis_tuser) begin
            $display("%t: mismatch expected %h/%0d actual %h/%0d", $time,
                     exp_r.value, exp_r.status, m_axis_tdata, m_axis_tuser);
            fails <= fails + 1;
          end
        end
      end
    end
  end

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

endmodule

/* tb/tb_top.sv */
// testbench top: stimulus, output stalls and verdict for the trig evaluator
`timescale 1ns / 1ps

module tb_top;
  import tte_pkg::*;

  localparam int LATENCY = 8 * 6 + 36;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          fail_count, pending;
  bit          stim_done = 1'b0;

  taylor_trig_evaluator dut (.*);

  tte_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  typedef struct {
    logic [2:0]  op;
    logic [31:0] x;
  } trig_request_t;

  trig_request_t request_q[$];

  task automatic add_request(logic [2:0] op, logic [31:0] x);
    request_q.push_back('{op, x});
  endtask

  function automatic logic [31:0] rand_operand();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1:    return $urandom();
      2, 3, 4: return 32'($signed($urandom_range(0, 32'h1000_0000)))
                      * ($urandom_range(0, 1) ? -1 : 1);
      5, 6:    return 32'($signed($urandom_range(0, 32'h1A00_0000)))
                      * ($urandom_range(0, 1) ? -1 : 1);
      7:       return PI_HALF_Q28 + 32'($urandom_range(0, 8)) - 32'd4;
      8:       return 32'h1000_0000 + 32'($urandom_range(0, 8)) - 32'd4;
      default: return 32'($urandom_range(0, 4096)) - 32'd2048;
    endcase
  endfunction

  // directed extremes and special cases first, then random requests
  initial begin
    logic [2:0] op;
    int         idle;
    for (int o = 0; o < 8; o++) begin
      op = o[2:0];
      add_request(op, 32'h0000_0000);
      add_request(op, 32'h7FFF_FFFF);
      add_request(op, 32'h8000_0000);
    end
    add_request(OP_TAN, PI_HALF_Q28);
    add_request(OP_TAN, PI_HALF_Q28 + 1);
    add_request(OP_TAN, -PI_HALF_Q28);
    add_request(OP_ASIN, ONE_Q28);
    add_request(OP_ACOS, ONE_Q28 + 1);
    add_request(OP_ACOS, -ONE_Q28);
    for (int i = 0; i < 1320; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
      add_request(op, rand_operand());
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < request_q.size(); i++) begin
      idle = $urandom_range(0, 5);
      if (idle > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= request_q[i].x;
      s_axis_tuser  <= request_q[i].op;
      do @(posedge clk_i); while (!s_axis_tready);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // receiver: a long hold-off early on so the pipeline fills, then a random
  // wait before each result
  initial begin
    int hold;
    @(posedge rst_ni);
    hold = 0;
    while (hold < 1000) begin
      @(posedge clk_i);
      hold++;
    end
    m_axis_tready <= 1'b1;
    while (!stim_done) begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        hold = $urandom_range(0, 5);
        if (hold > 0) begin
          m_axis_tready <= 1'b0;
          repeat (hold) @(posedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
    m_axis_tready <= 1'b1;
  end

  initial begin
    #(2_000_000 * 12);
    $display("Regression FAIL");
    $finish;
  end

endmodule
